>>> rtl/amtd_pkg.sv
`default_nettype none

package amtd_pkg;

  typedef struct packed {
    logic signed [31:0] col0_x;
    logic signed [31:0] col0_y;
    logic signed [31:0] col0_z;
    logic signed [31:0] col1_x;
    logic signed [31:0] col1_y;
    logic signed [31:0] col1_z;
    logic signed [31:0] col2_x;
    logic signed [31:0] col2_y;
    logic signed [31:0] col2_z;
  } amtd_in_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic [31:0]        scale_x;
    logic [31:0]        scale_y;
    logic [31:0]        scale_z;
    logic [1:0]         status;
  } amtd_out_t;

  typedef struct packed {
    amtd_in_t item;
    logic     zero_axis;
  } amtd_qent_t;

  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic        neg;
    logic [63:0] opa;
    logic [32:0] den;
  } amtd_arith_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } amtd_arith_rsp_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ZERO_AXIS = 2'd1;
  localparam logic [1:0] STAT_SHEAR     = 2'd2;
  localparam logic [1:0] STAT_DEGEN     = 2'd3;

  localparam logic [15:0] TOL_RESET = 16'd7;

endpackage

`default_nettype wire

>>> rtl/affine_matrix_trs_decompose.sv
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_ready    amtd_in_t, nine Q16.16 matrix entries
// out      out  out_valid / out_ready  amtd_out_t, quaternion, scales, status
// cfg      in   cfg_we                 cfg_wdata, 16-bit dot product tolerance
//
// A valid matrix needs sixteen 64-step divisions and five 32-step square roots,
// all run on the one shared divide/root unit.
// A zero axis result follows the column lengths, a shear result the triple product.
// Transactions are taken into a two-entry queue while the back end works.
// Reset is synchronous and clears the queue, the sequencer and the output valid.
// A stalled output holds the back end; the front keeps filling the queue.
`default_nettype none

module affine_matrix_trs_decompose import amtd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire amtd_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output amtd_out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic            tol_r;
  logic [15:0]     tolerance_r;
  logic            q_full, q_push, q_nempty, q_pop;
  amtd_qent_t      q_wdata, q_rdata;
  amtd_arith_req_t arith_req;
  amtd_arith_rsp_t arith_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r <= TOL_RESET;
      tol_r       <= 1'b0;
    end else if (cfg_we) begin
      tolerance_r <= cfg_wdata;
      tol_r       <= 1'b1;
    end
  end

  amtd_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  amtd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .nempty (q_nempty),
    .rdata  (q_rdata)
  );

  amtd_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req),
    .rsp   (arith_rsp)
  );

  amtd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tolerance (tol_r ? tolerance_r : TOL_RESET),
    .q_nempty  (q_nempty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .arith_req (arith_req),
    .arith_rsp (arith_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/amtd_front.sv
`default_nettype none

module amtd_front import amtd_pkg::*; (
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire amtd_in_t   in_data,
  input  wire logic       q_full,
  output logic            q_push,
  output amtd_qent_t      q_wdata
);

  logic zero0, zero1, zero2;

  assign zero0 = (in_data.col0_x == '0) && (in_data.col0_y == '0) && (in_data.col0_z == '0);
  assign zero1 = (in_data.col1_x == '0) && (in_data.col1_y == '0) && (in_data.col1_z == '0);
  assign zero2 = (in_data.col2_x == '0) && (in_data.col2_y == '0) && (in_data.col2_z == '0);

  assign in_ready          = !q_full;
  assign q_push            = in_valid && !q_full;
  assign q_wdata.item      = in_data;
  assign q_wdata.zero_axis = zero0 || zero1 || zero2;

endmodule

`default_nettype wire

>>> rtl/amtd_queue.sv
`default_nettype none

module amtd_queue import amtd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire amtd_qent_t wdata,
  output logic            full,
  input  wire logic       pop,
  output logic            nempty,
  output amtd_qent_t      rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  amtd_qent_t     mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign nempty  = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && nempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/amtd_arith.sv
`default_nettype none

module amtd_arith import amtd_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire amtd_arith_req_t req,
  output amtd_arith_rsp_t      rsp
);

  logic        busy_r, done_r, is_sqrt_r, neg_r;
  logic [6:0]  cnt_r;
  logic [63:0] sh_r, quo_r;
  logic [35:0] rem_r;
  logic [32:0] den_r;
  logic [35:0] div_sh, sq_sh, sq_trial, rem_nxt;
  logic        div_ge, sq_ge, bit_nxt;

  assign div_sh   = {rem_r[34:0], sh_r[63]};
  assign div_ge   = div_sh >= {3'b000, den_r};
  assign sq_sh    = {rem_r[33:0], sh_r[63:62]};
  assign sq_trial = {2'b00, quo_r[31:0], 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  always_comb begin
    if (is_sqrt_r) begin
      bit_nxt = sq_ge;
      rem_nxt = sq_ge ? sq_sh - sq_trial : sq_sh;
    end else begin
      bit_nxt = div_ge;
      rem_nxt = div_ge ? div_sh - {3'b000, den_r} : div_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_sqrt_r <= req.is_sqrt;
      neg_r     <= req.neg;
      den_r     <= req.den;
      sh_r      <= req.opa + {32'd0, req.den[32:1]};
      quo_r     <= '0;
      rem_r     <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[62:0], bit_nxt};
      sh_r  <= is_sqrt_r ? {sh_r[61:0], 2'b00} : {sh_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.is_sqrt ? 7'd31 : 7'd63;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = neg_r ? 64'd0 - quo_r : quo_r;

endmodule

`default_nettype wire

>>> rtl/amtd_back.sv
`default_nettype none

module amtd_back import amtd_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [15:0]     tolerance,
  input  wire logic            q_nempty,
  input  wire amtd_qent_t      q_rdata,
  output logic                 q_pop,
  output amtd_arith_req_t      arith_req,
  input  wire amtd_arith_rsp_t arith_rsp,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output amtd_out_t            out_data
);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_LEN   = 14'b00000000000010,
    ST_LRT   = 14'b00000000000100,
    ST_UDIV  = 14'b00000000001000,
    ST_DOT   = 14'b00000000010000,
    ST_CROSS = 14'b00000000100000,
    ST_TRIP  = 14'b00000001000000,
    ST_TRACE = 14'b00000010000000,
    ST_RRT   = 14'b00000100000000,
    ST_TDIV  = 14'b00001000000000,
    ST_NSQ   = 14'b00010000000000,
    ST_NRT   = 14'b00100000000000,
    ST_QDIV  = 14'b01000000000000,
    ST_DONE  = 14'b10000000000000
  } state_t;

  function automatic logic [3:0] idx9(input logic [1:0] col, input logic [1:0] row);
    idx9 = 4'({col, 1'b0}) + 4'(col) + 4'(row);
  endfunction

  function automatic logic [1:0] nxt3(input logic [1:0] k);
    nxt3 = (k == 2'd2) ? 2'd0 : k + 2'd1;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'd0 - v : v;
  endfunction

  state_t                state_r;
  logic                  ph_r, fail_r, zero_r, out_valid_r;
  logic [1:0]            j_r, major_r, status_r;
  logic [3:0]            k_r;
  logic signed [31:0]    c_r [9];
  logic signed [31:0]    u_r [9];
  logic [31:0]           len_r [3];
  logic signed [32:0]    cr_r [3];
  logic signed [31:0]    t_r [4];
  logic signed [31:0]    q_r [4];
  logic [31:0]           r_r, norm_r;
  logic [63:0]           acc_r, prod_r;
  amtd_out_t             out_r;

  logic signed [32:0]    mul_a;
  logic signed [31:0]    mul_b;
  logic signed [64:0]    mul_p;
  logic [1:0]            last_j, k1, k2, pa_col, pb_col, ucol;
  logic                  term_neg, group_end;
  logic [63:0]           acc_sum, acc_mag, cr_sum;
  logic [32:0]           cr_q;
  logic signed [34:0]    u0e, u4e, u8e, trace, arg;
  logic [1:0]            major;
  logic [32:0]           arg_u, half_sum;
  logic signed [32:0]    d21, d02, d10, s01, s02, s12, tnum;
  logic [32:0]           tmag;
  logic signed [63:0]    res_s;
  logic [31:0]           clamped;
  logic                  take_out;

  assign k1 = nxt3(k_r[1:0]);
  assign k2 = nxt3(k1);
  assign pa_col = (k_r[1:0] == 2'd2) ? 2'd1 : 2'd0;
  assign pb_col = (k_r[1:0] == 2'd0) ? 2'd1 : 2'd2;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_LEN: begin
        mul_a = {c_r[idx9(k_r[1:0], j_r)][31], c_r[idx9(k_r[1:0], j_r)]};
        mul_b = c_r[idx9(k_r[1:0], j_r)];
      end
      ST_DOT: begin
        mul_a = {u_r[idx9(pa_col, j_r)][31], u_r[idx9(pa_col, j_r)]};
        mul_b = u_r[idx9(pb_col, j_r)];
      end
      ST_CROSS: begin
        if (j_r == 2'd0) begin
          mul_a = {u_r[idx9(2'd0, k1)][31], u_r[idx9(2'd0, k1)]};
          mul_b = u_r[idx9(2'd1, k2)];
        end else begin
          mul_a = {u_r[idx9(2'd0, k2)][31], u_r[idx9(2'd0, k2)]};
          mul_b = u_r[idx9(2'd1, k1)];
        end
      end
      ST_TRIP: begin
        mul_a = cr_r[j_r];
        mul_b = u_r[idx9(2'd2, j_r)];
      end
      ST_NSQ: begin
        mul_a = {t_r[j_r][31], t_r[j_r]};
        mul_b = t_r[j_r];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (state_r)
      ST_CROSS: last_j = 2'd1;
      ST_NSQ:   last_j = 2'd3;
      default:  last_j = 2'd2;
    endcase
  end

  assign term_neg  = (state_r == ST_CROSS) && (j_r == 2'd1);
  assign acc_sum   = term_neg ? acc_r - prod_r : acc_r + prod_r;
  assign acc_mag   = acc_sum[63] ? 64'd0 - acc_sum : acc_sum;
  assign group_end = ph_r && (j_r == last_j);
  assign cr_sum    = acc_mag + 64'd536870912;
  assign cr_q      = cr_sum[62:30];

  assign u0e   = {{3{u_r[0][31]}}, u_r[0]};
  assign u4e   = {{3{u_r[4][31]}}, u_r[4]};
  assign u8e   = {{3{u_r[8][31]}}, u_r[8]};
  assign trace = u0e + u4e + u8e;

  always_comb begin
    if (trace > 35'sd0) begin
      major = 2'd0;
      arg   = trace + 35'sd1073741824;
    end else if (u0e > u4e && u0e > u8e) begin
      major = 2'd1;
      arg   = 35'sd1073741824 + u0e - u4e - u8e;
    end else if (u4e > u8e) begin
      major = 2'd2;
      arg   = 35'sd1073741824 + u4e - u0e - u8e;
    end else begin
      major = 2'd3;
      arg   = 35'sd1073741824 + u8e - u0e - u4e;
    end
  end

  assign arg_u    = arg[34] ? '0 : arg[32:0];
  assign half_sum = {1'b0, r_r} + 33'd1;

  assign d21 = {u_r[5][31], u_r[5]} - {u_r[7][31], u_r[7]};
  assign d02 = {u_r[6][31], u_r[6]} - {u_r[2][31], u_r[2]};
  assign d10 = {u_r[1][31], u_r[1]} - {u_r[3][31], u_r[3]};
  assign s01 = {u_r[3][31], u_r[3]} + {u_r[1][31], u_r[1]};
  assign s02 = {u_r[6][31], u_r[6]} + {u_r[2][31], u_r[2]};
  assign s12 = {u_r[7][31], u_r[7]} + {u_r[5][31], u_r[5]};

  always_comb begin
    case ({major_r, k_r[1:0]})
      4'b0001: tnum = d21;
      4'b0010: tnum = d02;
      4'b0011: tnum = d10;
      4'b0100: tnum = d21;
      4'b0110: tnum = s01;
      4'b0111: tnum = s02;
      4'b1000: tnum = d02;
      4'b1001: tnum = s01;
      4'b1011: tnum = s12;
      4'b1100: tnum = d10;
      4'b1101: tnum = s02;
      4'b1110: tnum = s12;
      default: tnum = '0;
    endcase
  end

  assign tmag  = tnum[32] ? 33'd0 - tnum : tnum;
  assign res_s = arith_rsp.res;

  always_comb begin
    if (res_s > 64'sd2147483647) begin
      clamped = 32'h7FFFFFFF;
    end else if (res_s < -64'sd2147483647) begin
      clamped = 32'h80000001;
    end else begin
      clamped = res_s[31:0];
    end
  end

  always_comb begin
    case (k_r)
      4'd0, 4'd1, 4'd2: ucol = 2'd0;
      4'd3, 4'd4, 4'd5: ucol = 2'd1;
      default:          ucol = 2'd2;
    endcase
  end

  always_comb begin
    arith_req = '0;
    case (state_r)
      ST_LEN: begin
        arith_req.start   = group_end;
        arith_req.is_sqrt = 1'b1;
        arith_req.opa     = acc_sum;
      end
      ST_NSQ: begin
        arith_req.start   = group_end;
        arith_req.is_sqrt = 1'b1;
        arith_req.opa     = acc_sum;
      end
      ST_TRACE: begin
        arith_req.start   = 1'b1;
        arith_req.is_sqrt = 1'b1;
        arith_req.opa     = {1'b0, arg_u, 30'd0};
      end
      ST_UDIV: begin
        arith_req.start = !ph_r;
        arith_req.neg   = c_r[k_r][31];
        arith_req.opa   = {2'b00, mag32(c_r[k_r]), 30'd0};
        arith_req.den   = {1'b0, len_r[ucol]};
      end
      ST_TDIV: begin
        arith_req.start = !ph_r && (k_r[1:0] != major_r);
        arith_req.neg   = tnum[32];
        arith_req.opa   = {1'b0, tmag, 30'd0};
        arith_req.den   = {r_r, 1'b0};
      end
      ST_QDIV: begin
        arith_req.start = !ph_r;
        arith_req.neg   = t_r[k_r[1:0]][31];
        arith_req.opa   = {2'b00, mag32(t_r[k_r[1:0]]), 30'd0};
        arith_req.den   = {1'b0, norm_r};
      end
      default: arith_req = '0;
    endcase
  end

  assign q_pop    = (state_r == ST_IDLE) && q_nempty;
  assign take_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!ph_r) begin
      prod_r <= mul_p[63:0];
    end
    case (state_r)
      ST_IDLE: begin
        if (q_nempty) begin
          c_r[0] <= q_rdata.item.col0_x;
          c_r[1] <= q_rdata.item.col0_y;
          c_r[2] <= q_rdata.item.col0_z;
          c_r[3] <= q_rdata.item.col1_x;
          c_r[4] <= q_rdata.item.col1_y;
          c_r[5] <= q_rdata.item.col1_z;
          c_r[6] <= q_rdata.item.col2_x;
          c_r[7] <= q_rdata.item.col2_y;
          c_r[8] <= q_rdata.item.col2_z;
          zero_r <= q_rdata.zero_axis;
          acc_r  <= '0;
        end
      end
      ST_LEN, ST_DOT, ST_CROSS, ST_TRIP, ST_NSQ: begin
        if (ph_r) begin
          acc_r <= group_end ? '0 : acc_sum;
        end
        if (group_end && state_r == ST_CROSS) begin
          cr_r[k_r[1:0]] <= acc_sum[63] ? 33'd0 - cr_q : cr_q;
        end
      end
      ST_LRT: begin
        if (arith_rsp.done) begin
          len_r[k_r[1:0]] <= arith_rsp.res[31:0];
        end
      end
      ST_UDIV: begin
        if (ph_r && arith_rsp.done) begin
          u_r[k_r] <= arith_rsp.res[31:0];
        end
      end
      ST_TRACE: begin
        major_r <= major;
      end
      ST_RRT: begin
        if (arith_rsp.done) begin
          r_r <= arith_rsp.res[31:0];
        end
      end
      ST_TDIV: begin
        if (!ph_r && k_r[1:0] == major_r) begin
          t_r[k_r[1:0]] <= half_sum[32:1];
        end else if (ph_r && arith_rsp.done) begin
          t_r[k_r[1:0]] <= clamped;
        end
      end
      ST_NRT: begin
        if (arith_rsp.done) begin
          norm_r <= arith_rsp.res[31:0];
        end
      end
      ST_QDIV: begin
        if (ph_r && arith_rsp.done) begin
          q_r[k_r[1:0]] <= arith_rsp.res[31:0];
        end
      end
      default: begin
      end
    endcase
    if (take_out) begin
      out_r.quat_w  <= (status_r == STAT_OK) ? q_r[0] : '0;
      out_r.quat_x  <= (status_r == STAT_OK) ? q_r[1] : '0;
      out_r.quat_y  <= (status_r == STAT_OK) ? q_r[2] : '0;
      out_r.quat_z  <= (status_r == STAT_OK) ? q_r[3] : '0;
      out_r.scale_x <= len_r[0];
      out_r.scale_y <= len_r[1];
      out_r.scale_z <= len_r[2];
      out_r.status  <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= 1'b0;
      j_r         <= '0;
      k_r         <= '0;
      fail_r      <= 1'b0;
      status_r    <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (take_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_nempty) begin
            state_r <= ST_LEN;
            ph_r    <= 1'b0;
            j_r     <= '0;
            k_r     <= '0;
            fail_r  <= 1'b0;
          end
        end
        ST_LEN, ST_DOT, ST_CROSS, ST_TRIP, ST_NSQ: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            j_r <= group_end ? 2'd0 : j_r + 2'd1;
          end
          if (group_end) begin
            case (state_r)
              ST_LEN: state_r <= ST_LRT;
              ST_NSQ: state_r <= ST_NRT;
              ST_DOT: begin
                if (acc_mag > {4'd0, tolerance, 44'd0}) begin
                  fail_r <= 1'b1;
                end
                if (k_r == 4'd2) begin
                  k_r     <= '0;
                  state_r <= ST_CROSS;
                end else begin
                  k_r <= k_r + 4'd1;
                end
              end
              ST_CROSS: begin
                if (k_r == 4'd2) begin
                  k_r     <= '0;
                  state_r <= ST_TRIP;
                end else begin
                  k_r <= k_r + 4'd1;
                end
              end
              default: begin
                if (fail_r || acc_sum[63] || acc_sum == '0) begin
                  status_r <= STAT_SHEAR;
                  state_r  <= ST_DONE;
                end else begin
                  state_r <= ST_TRACE;
                end
              end
            endcase
          end
        end
        ST_LRT: begin
          if (arith_rsp.done) begin
            if (k_r == 4'd2) begin
              k_r <= '0;
              if (zero_r) begin
                status_r <= STAT_ZERO_AXIS;
                state_r  <= ST_DONE;
              end else begin
                state_r <= ST_UDIV;
              end
            end else begin
              k_r     <= k_r + 4'd1;
              state_r <= ST_LEN;
            end
          end
        end
        ST_UDIV: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else if (arith_rsp.done) begin
            ph_r <= 1'b0;
            if (k_r == 4'd8) begin
              k_r     <= '0;
              state_r <= ST_DOT;
            end else begin
              k_r <= k_r + 4'd1;
            end
          end
        end
        ST_TRACE: begin
          state_r <= ST_RRT;
        end
        ST_RRT: begin
          if (arith_rsp.done) begin
            k_r  <= '0;
            ph_r <= 1'b0;
            if (arith_rsp.res[31:0] == '0) begin
              status_r <= STAT_DEGEN;
              state_r  <= ST_DONE;
            end else begin
              state_r <= ST_TDIV;
            end
          end
        end
        ST_TDIV: begin
          if ((!ph_r && k_r[1:0] == major_r) || (ph_r && arith_rsp.done)) begin
            ph_r <= 1'b0;
            if (k_r == 4'd3) begin
              k_r     <= '0;
              j_r     <= '0;
              state_r <= ST_NSQ;
            end else begin
              k_r <= k_r + 4'd1;
            end
          end else if (!ph_r) begin
            ph_r <= 1'b1;
          end
        end
        ST_NRT: begin
          if (arith_rsp.done) begin
            k_r  <= '0;
            ph_r <= 1'b0;
            if (arith_rsp.res[31:0] == '0) begin
              status_r <= STAT_DEGEN;
              state_r  <= ST_DONE;
            end else begin
              state_r <= ST_QDIV;
            end
          end
        end
        ST_QDIV: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else if (arith_rsp.done) begin
            ph_r <= 1'b0;
            if (k_r == 4'd3) begin
              k_r      <= '0;
              status_r <= STAT_OK;
              state_r  <= ST_DONE;
            end else begin
              k_r <= k_r + 4'd1;
            end
          end
        end
        ST_DONE: begin
          if (take_out) begin
            status_r <= STAT_OK;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> rtl/amtd_checker.sv
`default_nettype none

module amtd_checker import amtd_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire amtd_out_t   out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result transaction withdrawn before it was taken.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("Stalled result transaction changed.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_err_zero_quat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |->
      out_data.quat_w == '0 && out_data.quat_x == '0 &&
      out_data.quat_y == '0 && out_data.quat_z == '0)
    else $error("Error result carries a nonzero quaternion.");

  a_zero_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_ZERO_AXIS |->
      out_data.scale_x == '0 || out_data.scale_y == '0 || out_data.scale_z == '0)
    else $error("Zero axis status without a zero scale.");

endmodule

bind affine_matrix_trs_decompose amtd_checker u_chk (.*);

`default_nettype wire

>>> verif/decompose_checker.sv
`timescale 1ns / 1ps

module decompose_checker import amtd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  amtd_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  amtd_out_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint COMP_LIM = 64'sd2147483647;

  logic [15:0] tol_q;
  amtd_out_t   expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint rdiv(longint num, logic [63:0] den);
    logic [63:0] q;
    q = (mag(num) + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clampc(longint v);
    if (v > COMP_LIM) return COMP_LIM;
    if (v < -COMP_LIM) return -COMP_LIM;
    return v;
  endfunction

  function automatic amtd_out_t decompose(amtd_in_t m_in, logic [15:0] tol);
    amtd_out_t   res;
    longint      col[3][3];
    longint      u[3][3];
    longint      m[3][3];
    longint      t[4];
    logic [63:0] len[3];
    logic [63:0] acc;
    logic [63:0] lim;
    logic [63:0] r;
    logic [63:0] nrm;
    longint      d;
    longint      cx;
    longint      cy;
    longint      cz;
    longint      tr;
    longint      arg;
    longint      hf;
    longint      d21;
    longint      d02;
    longint      d10;
    longint      s01;
    longint      s02;
    longint      s12;
    int          major;
    logic [1:0]  st;
    st = STAT_OK;
    col[0] = '{m_in.col0_x, m_in.col0_y, m_in.col0_z};
    col[1] = '{m_in.col1_x, m_in.col1_y, m_in.col1_z};
    col[2] = '{m_in.col2_x, m_in.col2_y, m_in.col2_z};
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += mag(col[k][j]) * mag(col[k][j]);
      len[k] = isqrt(acc);
      if (len[k] > 64'hFFFFFFFF) len[k] = 64'hFFFFFFFF;
      if (len[k] == 0) st = STAT_ZERO_AXIS;
    end
    t = '{0, 0, 0, 0};
    if (st == STAT_OK) begin
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++) u[k][j] = rdiv(col[k][j] * ONE_Q30, len[k]);
      lim = 64'(tol) << 44;
      for (int p = 0; p < 3; p++) begin
        int a;
        int b;
        a = (p == 2) ? 1 : 0;
        b = (p == 0) ? 1 : 2;
        d = 0;
        for (int j = 0; j < 3; j++) d += u[a][j] * u[b][j];
        if (mag(d) > lim) st = STAT_SHEAR;
      end
      cx = rdiv(u[0][1] * u[1][2] - u[0][2] * u[1][1], ONE_Q30);
      cy = rdiv(u[0][2] * u[1][0] - u[0][0] * u[1][2], ONE_Q30);
      cz = rdiv(u[0][0] * u[1][1] - u[0][1] * u[1][0], ONE_Q30);
      if (cx * u[2][0] + cy * u[2][1] + cz * u[2][2] <= 0) st = STAT_SHEAR;
      if (st == STAT_OK) begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) m[i][j] = u[j][i];
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
          arg = tr + ONE_Q30; major = 0;
        end else if (m[0][0] > m[1][1] && m[0][0] > m[2][2]) begin
          arg = ONE_Q30 + m[0][0] - m[1][1] - m[2][2]; major = 1;
        end else if (m[1][1] > m[2][2]) begin
          arg = ONE_Q30 + m[1][1] - m[0][0] - m[2][2]; major = 2;
        end else begin
          arg = ONE_Q30 + m[2][2] - m[0][0] - m[1][1]; major = 3;
        end
        if (arg < 0) arg = 0;
        r = isqrt(64'(arg) << 30);
        if (r == 0) begin
          st = STAT_DEGEN;
        end else begin
          hf = longint'((r + 1) >> 1);
          d21 = m[2][1] - m[1][2]; d02 = m[0][2] - m[2][0]; d10 = m[1][0] - m[0][1];
          s01 = m[0][1] + m[1][0]; s02 = m[0][2] + m[2][0]; s12 = m[1][2] + m[2][1];
          case (major)
            0: t = '{hf, rdiv(d21 * ONE_Q30, 2 * r), rdiv(d02 * ONE_Q30, 2 * r),
                     rdiv(d10 * ONE_Q30, 2 * r)};
            1: t = '{rdiv(d21 * ONE_Q30, 2 * r), hf, rdiv(s01 * ONE_Q30, 2 * r),
                     rdiv(s02 * ONE_Q30, 2 * r)};
            2: t = '{rdiv(d02 * ONE_Q30, 2 * r), rdiv(s01 * ONE_Q30, 2 * r), hf,
                     rdiv(s12 * ONE_Q30, 2 * r)};
            default: t = '{rdiv(d10 * ONE_Q30, 2 * r), rdiv(s02 * ONE_Q30, 2 * r),
                           rdiv(s12 * ONE_Q30, 2 * r), hf};
          endcase
          acc = 0;
          for (int i = 0; i < 4; i++) begin
            t[i] = clampc(t[i]);
            acc += mag(t[i]) * mag(t[i]);
          end
          nrm = isqrt(acc);
          if (nrm == 0) begin
            st = STAT_DEGEN;
            t = '{0, 0, 0, 0};
          end else begin
            for (int i = 0; i < 4; i++) t[i] = rdiv(t[i] * ONE_Q30, nrm);
          end
        end
        if (st != STAT_OK) t = '{0, 0, 0, 0};
      end
    end
    res.quat_w = t[0][31:0];
    res.quat_x = t[1][31:0];
    res.quat_y = t[2][31:0];
    res.quat_z = t[3][31:0];
    res.scale_x = len[0][31:0];
    res.scale_y = len[1][31:0];
    res.scale_z = len[2][31:0];
    res.status = st;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("Mismatch on %s: got %h, expected %h", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    amtd_out_t want;
    if (!rst_n) begin
      tol_q <= TOL_RESET;
      expected_q.delete();
    end else begin
      if (cfg_we) tol_q <= cfg_wdata;
      if (in_valid && in_ready) expected_q = {expected_q, decompose(in_data, tol_q)};
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("Unexpected result transaction");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.quat_w !== want.quat_w)
            report_mismatch("quat_w", out_data.quat_w, want.quat_w);
          if (out_data.quat_x !== want.quat_x)
            report_mismatch("quat_x", out_data.quat_x, want.quat_x);
          if (out_data.quat_y !== want.quat_y)
            report_mismatch("quat_y", out_data.quat_y, want.quat_y);
          if (out_data.quat_z !== want.quat_z)
            report_mismatch("quat_z", out_data.quat_z, want.quat_z);
          if (out_data.scale_x !== want.scale_x)
            report_mismatch("scale_x", out_data.scale_x, want.scale_x);
          if (out_data.scale_y !== want.scale_y)
            report_mismatch("scale_y", out_data.scale_y, want.scale_y);
          if (out_data.scale_z !== want.scale_z)
            report_mismatch("scale_z", out_data.scale_z, want.scale_z);
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
        end
      end
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import amtd_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int ONE = 65536;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  amtd_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  amtd_out_t   out_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          hold_off;
  bit          done;

  affine_matrix_trs_decompose i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  decompose_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic amtd_in_t mk(int a0, int a1, int a2, int b0, int b1, int b2,
                                  int c0, int c1, int c2);
    amtd_in_t m;
    m = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    return m;
  endfunction

  function automatic int rnd_entry();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
      2: return 0;
      default: return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
    endcase
  endfunction

  // Mostly scaled, signed permutation matrices with small noise; one in four has random entries.
  function automatic amtd_in_t rnd_matrix();
    amtd_in_t m;
    int       e[9];
    int       p0;
    int       p1;
    int       p2;
    int       sg;
    int       s;
    if ($urandom_range(0, 3) == 0) begin
      foreach (e[i]) e[i] = rnd_entry();
    end else begin
      p0 = $urandom_range(0, 2);
      p1 = (p0 + 1 + $urandom_range(0, 1)) % 3;
      p2 = 3 - p0 - p1;
      foreach (e[i]) e[i] = $urandom_range(0, 1) ? int'($urandom_range(0, 6)) - 3 : 0;
      for (int k = 0; k < 3; k++) begin
        s = $urandom_range(1, 8 * ONE);
        sg = $urandom_range(0, 1) ? -1 : 1;
        e[3 * k + (k == 0 ? p0 : (k == 1 ? p1 : p2))] = sg * s;
      end
    end
    m = '{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return m;
  endfunction

  task automatic send(amtd_in_t m);
    in_data <= m;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (1500) @(negedge clk);
  endtask

  task automatic write_tol(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int c;
    c = 0;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      c++;
      if (hold_off) out_ready <= 1'b0;
      else if ((c / 200) % 3 == 0) out_ready <= 1'b1;
      else out_ready <= $urandom_range(0, 3) != 0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !done) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int burst;
    done = 1'b0;
    hold_off = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send(mk(0, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send(mk(ONE, 0, 0, 0, 0, 0, 0, 0, ONE));
    send(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, 0));
    send(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
    send(mk(ONE, ONE, 0, 0, ONE, 0, 0, 0, ONE));
    send(mk(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
    send(mk(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
    send(mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE));
    send(mk(0, ONE, 0, -ONE, 0, 0, 0, 0, ONE));
    send(mk(3 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 5 * ONE));
    send(mk(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send(mk(32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF));
    send(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
    send(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    send(mk(46341, 46341, 0, -46341, 46341, 0, 0, 0, ONE));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_tol(16'd0);
        1: write_tol(16'hFFFF);
        2: write_tol(16'd7);
        3: write_tol(16'd300);
        default: write_tol(16'($urandom()));
      endcase
      for (int n = 0; n < 400; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < 400; b++, n++) send(rnd_matrix());
        in_valid <= 1'b0;
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 40)) @(negedge clk);
        if (ph == 1 && n >= 200 && n < 212) begin
          hold_off = 1'b1;
          fork
            begin
              repeat (6000) @(negedge clk);
              hold_off = 1'b0;
            end
            for (int b = 0; b < 5; b++, n++) send(rnd_matrix());
          join
          in_valid <= 1'b0;
        end
        if (ph == 3 && n >= 200 && n < 213) begin
          while (pending != 0) @(negedge clk);
        end
      end
      drain();
    end

    done = 1'b1;
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
